// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg: shared constants for the lfu cache with lru tie-break
// Key width, command codes, capacity register layout and parameter defaults.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam int DEF_ENTRIES     = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

endpackage

// ----- sv/lfu_cache_lru_tiebreak.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak: key-only lfu cache, least recent evicted on ties
// Entry memory with a scan pass per operation and a read-modify-write pass for all but a get that misses.
// ----------------------------------------------------------------------------
// Each entry (key, saturating use count, recency rank) lives in one synchronous
// single-read memory of ENTRIES words; valid bits and the occupancy count are
// flip-flops. One operation at a time: a scan pass reads every entry once to find
// the key, the victim and the first free slot, then a write-back pass reads and
// rewrites every entry to move ranks and place the touched or new entry. Both
// passes go over the memory at one entry per cycle, and a get that misses skips
// the write-back pass; the next transfer is taken once the result is registered.
// A finished result sits in the output register while the next item is taken.
// The capacity register may be written at any time the block is idle; values of
// zero act as one and values above ENTRIES act as ENTRIES.
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
#(
    parameter int ENTRIES     = DEF_ENTRIES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_capacity,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic signed [KEY_W-1:0] i_key,
    // results
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic signed [KEY_W-1:0] o_result_key,
    output logic                    o_evicted,
    output logic signed [KEY_W-1:0] o_evicted_key
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CAP_W > OCC_W) ? CAP_W : OCC_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [COUNT_WIDTH-1:0] count;
        logic [RANK_W-1:0]      rank;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CAP_W-1:0]       r_cap;
    logic [ENTRIES-1:0]     r_valid;
    logic [OCC_W-1:0]       r_occ;

    logic [KEY_W-1:0]       r_key;
    logic                   r_cmd;

    logic [IDX_W-1:0]       r_addr;
    logic                   r_iss;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_paddr;

    t_entry                 r_mem [ENTRIES];
    t_entry                 r_rd_data;

    // scan results
    logic                   r_found;
    logic [IDX_W-1:0]       r_found_idx;
    logic [COUNT_WIDTH-1:0] r_found_count;
    logic [RANK_W-1:0]      r_found_rank;
    logic                   r_vict_ok;
    logic [IDX_W-1:0]       r_vict_idx;
    logic [COUNT_WIDTH-1:0] r_vict_count;
    logic [RANK_W-1:0]      r_vict_rank;
    logic [KEY_W-1:0]       r_vict_key;
    logic                   r_free_ok;
    logic [IDX_W-1:0]       r_free_idx;

    // write-back pass control
    logic                   r_tgt_ok;
    logic [IDX_W-1:0]       r_tgt_idx;
    t_entry                 r_tgt_entry;
    logic                   r_dec_en;
    logic [RANK_W-1:0]      r_dec_rank;

    // pending result
    logic                   r_res_hit;
    logic                   r_res_evict;
    logic [KEY_W-1:0]       r_res_evkey;

    logic                   r_out_valid;
    logic                   r_o_hit;
    logic [KEY_W-1:0]       r_o_result_key;
    logic                   r_o_evicted;
    logic [KEY_W-1:0]       r_o_evicted_key;

    // combinational helpers
    logic                   w_cur_valid;
    logic                   w_match;
    logic                   w_better;
    logic [CMP_W-1:0]       w_eff_cap;
    logic                   w_evict;
    logic [OCC_W-1:0]       w_occ_new;
    logic                   w_ins_ok;
    logic [IDX_W-1:0]       w_ins_idx;
    logic [COUNT_WIDTH-1:0] w_hit_count;
    logic [ENTRIES-1:0]     n_valid;
    t_entry                 n_wr;
    logic                   w_we;

    assign w_cur_valid = r_valid[r_paddr];
    assign w_match     = w_cur_valid && (r_rd_data.key == r_key);
    assign w_better    = w_cur_valid &&
                         (!r_vict_ok ||
                          (r_rd_data.count < r_vict_count) ||
                          ((r_rd_data.count == r_vict_count) &&
                           (r_rd_data.rank < r_vict_rank)));

    always_comb begin
        w_eff_cap = CMP_W'(r_cap);
        if (w_eff_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end
        if (w_eff_cap > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end
    end

    always_comb begin
        w_evict   = (CMP_W'(r_occ) >= w_eff_cap) && (r_occ != '0) && r_vict_ok;
        w_occ_new = r_occ - OCC_W'(w_evict);
        w_ins_ok  = w_evict || r_free_ok;
        // lowest free slot once the victim has left
        if (w_evict && (!r_free_ok || (r_vict_idx < r_free_idx))) begin
            w_ins_idx = r_vict_idx;
        end else begin
            w_ins_idx = r_free_idx;
        end
        w_hit_count = (r_found_count == '1) ? r_found_count
                                            : r_found_count + 1'b1;
        n_valid = r_valid;
        if (w_evict) begin
            n_valid[r_vict_idx] = 1'b0;
        end
        if (w_ins_ok) begin
            n_valid[w_ins_idx] = 1'b1;
        end
    end

    always_comb begin
        n_wr = r_rd_data;
        if (r_tgt_ok && (r_paddr == r_tgt_idx)) begin
            n_wr = r_tgt_entry;
        end else if (r_dec_en && w_cur_valid && (r_rd_data.rank > r_dec_rank)) begin
            n_wr.rank = r_rd_data.rank - 1'b1;
        end
    end

    assign w_we = (r_state == S_UPDATE) && r_pend;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_paddr] <= n_wr;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAPACITY_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_iss       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_capacity;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key     <= i_key;
                        r_cmd     <= i_command;
                        r_addr    <= '0;
                        r_iss     <= 1'b1;
                        r_pend    <= 1'b0;
                        r_found   <= 1'b0;
                        r_vict_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend  <= r_iss;
                    r_paddr <= r_addr;
                    if (r_iss) begin
                        if (r_addr == LAST) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_pend) begin
                        if (w_match && !r_found) begin
                            r_found       <= 1'b1;
                            r_found_idx   <= r_paddr;
                            r_found_count <= r_rd_data.count;
                            r_found_rank  <= r_rd_data.rank;
                        end
                        if (w_better) begin
                            r_vict_ok    <= 1'b1;
                            r_vict_idx   <= r_paddr;
                            r_vict_count <= r_rd_data.count;
                            r_vict_rank  <= r_rd_data.rank;
                            r_vict_key   <= r_rd_data.key;
                        end
                        if (!w_cur_valid && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_paddr;
                        end
                        if (r_paddr == LAST) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_addr      <= '0;
                    r_pend      <= 1'b0;
                    r_res_hit   <= r_found;
                    if (r_found) begin
                        r_iss             <= 1'b1;
                        r_res_evict       <= 1'b0;
                        r_res_evkey       <= '0;
                        r_tgt_ok          <= 1'b1;
                        r_tgt_idx         <= r_found_idx;
                        r_tgt_entry.key   <= r_key;
                        r_tgt_entry.count <= w_hit_count;
                        r_tgt_entry.rank  <= RANK_W'(r_occ - 1'b1);
                        r_dec_en          <= 1'b1;
                        r_dec_rank        <= r_found_rank;
                        r_state           <= S_UPDATE;
                    end else if (r_cmd == CMD_GET) begin
                        r_iss       <= 1'b0;
                        r_res_evict <= 1'b0;
                        r_res_evkey <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        // put miss: evict if at capacity, then insert
                        r_iss             <= 1'b1;
                        r_res_evict       <= w_evict;
                        r_res_evkey       <= w_evict ? r_vict_key : '0;
                        r_tgt_ok          <= w_ins_ok;
                        r_tgt_idx         <= w_ins_idx;
                        r_tgt_entry.key   <= r_key;
                        r_tgt_entry.count <= COUNT_WIDTH'(1);
                        r_tgt_entry.rank  <= RANK_W'(w_occ_new);
                        r_dec_en          <= w_evict;
                        r_dec_rank        <= r_vict_rank;
                        r_valid           <= n_valid;
                        r_occ   <= w_occ_new + OCC_W'(w_ins_ok);
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_pend  <= r_iss;
                    r_paddr <= r_addr;
                    if (r_iss) begin
                        if (r_addr == LAST) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_pend && (r_paddr == LAST)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid     <= 1'b1;
                        r_o_hit         <= r_res_hit;
                        r_o_result_key  <= r_res_hit ? r_key : '0;
                        r_o_evicted     <= r_res_evict;
                        r_o_evicted_key <= r_res_evkey;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_result_key  = r_o_result_key;
    assign o_evicted     = r_o_evicted;
    assign o_evicted_key = r_o_evicted_key;

    // occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy differs from number of valid entries");

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= ENTRIES)
        else $error("occupancy above built depth");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("result shows both hit and eviction");

    // memory writes only during the write-back pass
    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_UPDATE) && !o_in_ready)
        else $error("entry memory written outside write-back pass");

endmodule
